// File: rtl/cst_pkg.sv
// cst_pkg: shared types, codes and character tables of the c-style token scanner
// no dependencies; used by cst_step and c_style_token_scanner
package cst_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int MAX_NEST_DEF    = 15;
  localparam int OPT_W  = 6;
  localparam int KIND_W = 6;
  localparam int ERR_W  = 4;
  localparam int VAL_W  = 64;
  localparam int POS_W  = 32;

  // option bits
  localparam int OPT_NO_NL    = 0;
  localparam int OPT_STR_ESC  = 1;
  localparam int OPT_STR_NONL = 2;
  localparam int OPT_XML      = 3;
  localparam int OPT_LINE     = 4;
  localparam int OPT_BLOCK    = 5;

  // token kinds
  localparam logic [KIND_W-1:0] K_EOF = 6'd0, K_NL = 6'd1, K_INT = 6'd2, K_FLOAT = 6'd3,
    K_STR = 6'd4, K_NAME = 6'd5, K_DOT = 6'd6, K_ELLIPSIS = 6'd7, K_LT = 6'd8,
    K_LSHIFT = 6'd9, K_LSHIFT_AS = 6'd10, K_LE = 6'd11, K_GT = 6'd12, K_RSHIFT = 6'd13,
    K_RSHIFT_AS = 6'd14, K_GE = 6'd15, K_SLASH = 6'd16, K_SLASH_AS = 6'd17,
    K_LPAREN = 6'd18, K_RPAREN = 6'd19, K_LBRACE = 6'd20, K_RBRACE = 6'd21,
    K_LBRACK = 6'd22, K_RBRACK = 6'd23, K_COMMA = 6'd24, K_AT = 6'd25, K_HASH = 6'd26,
    K_QUEST = 6'd27, K_SEMI = 6'd28, K_TILDE = 6'd29, K_BANG = 6'd30, K_NE = 6'd31,
    K_COLON = 6'd32, K_DCOLON = 6'd33, K_COLON_AS = 6'd34, K_ASSIGN = 6'd35,
    K_EQ = 6'd36, K_XOR = 6'd37, K_XOR_AS = 6'd38, K_STAR = 6'd39, K_STAR_AS = 6'd40,
    K_MOD = 6'd41, K_MOD_AS = 6'd42, K_PLUS = 6'd43, K_PLUS_AS = 6'd44, K_INC = 6'd45,
    K_MINUS = 6'd46, K_MINUS_AS = 6'd47, K_DEC = 6'd48, K_AND = 6'd49, K_AND_AS = 6'd50,
    K_LAND = 6'd51, K_OR = 6'd52, K_OR_AS = 6'd53, K_LOR = 6'd54, K_INVALID = 6'd55;

  // error codes
  localparam logic [ERR_W-1:0] E_NONE = 4'd0, E_RANGE = 4'd1, E_OVF = 4'd2,
    E_BAD_BYTE = 4'd3, E_CHAR_EMPTY = 4'd4, E_CHAR_NL = 4'd5, E_CHAR_ESC = 4'd6,
    E_CHAR_OPEN = 4'd7, E_STR_BAD = 4'd8, E_STR_OPEN = 4'd9, E_EXP = 4'd10;

  localparam logic [4:0] BASE_2 = 5'd2, BASE_8 = 5'd8, BASE_10 = 5'd10, BASE_16 = 5'd16;

  typedef enum logic [4:0] {
    M_IDLE, M_NAME, M_ZERO, M_NUM, M_NUM_OVF, M_INT, M_INT_SKIP, M_FRAC,
    M_EXP, M_EXP_SIGN, M_EXP_DIG, M_DOT, M_OP1, M_OP2, M_CHAR_OPEN,
    M_CHAR_ESC, M_CHAR_CLOSE, M_STR, M_STR_ESC, M_LINE, M_XML, M_BLK,
    M_BLK_SLASH, M_BLK_STAR
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [VAL_W-1:0]  acc;
    logic [4:0]        base;
    logic [1:0]        dots;
    logic [ERR_W-1:0]  err;
  } scan_st_t;

  typedef struct packed {
    logic              hit;
    logic              multi;
    logic [KIND_W-1:0] k1;
    logic [7:0]        c2;
    logic [KIND_W-1:0] k2;
    logic [7:0]        c3;
    logic [KIND_W-1:0] k3;
  } op_info_t;

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  // 16 means not a hex digit
  function automatic logic [4:0] hexval(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (is_dig(b)) v = 5'(b - 8'h30);
    else if ((b >= "a") && (b <= "f")) v = 5'(b - 8'h57);
    else if ((b >= "A") && (b <= "F")) v = 5'(b - 8'h37);
    return v;
  endfunction

  // 256 means unknown escape
  function automatic logic [8:0] escape_of(input logic [7:0] b);
    logic [8:0] v;
    case (b)
      "n":     v = 9'd10;
      "r":     v = 9'd13;
      "t":     v = 9'd9;
      "v":     v = 9'd11;
      "b":     v = 9'd8;
      "a":     v = 9'd7;
      "f":     v = 9'd12;
      "0":     v = 9'd0;
      "\\":    v = 9'd92;
      "'":     v = 9'd39;
      "\"":    v = 9'd34;
      "?":     v = 9'd63;
      default: v = 9'd256;
    endcase
    return v;
  endfunction

  function automatic op_info_t op_info(input logic [7:0] c);
    op_info_t o;
    o = '{hit: 1'b1, multi: 1'b1, k1: K_INVALID, c2: 8'h00, k2: K_EOF, c3: 8'h00, k3: K_EOF};
    case (c)
      "(": begin o.multi = 1'b0; o.k1 = K_LPAREN; end
      ")": begin o.multi = 1'b0; o.k1 = K_RPAREN; end
      "{": begin o.multi = 1'b0; o.k1 = K_LBRACE; end
      "}": begin o.multi = 1'b0; o.k1 = K_RBRACE; end
      "[": begin o.multi = 1'b0; o.k1 = K_LBRACK; end
      "]": begin o.multi = 1'b0; o.k1 = K_RBRACK; end
      ",": begin o.multi = 1'b0; o.k1 = K_COMMA; end
      "@": begin o.multi = 1'b0; o.k1 = K_AT; end
      "#": begin o.multi = 1'b0; o.k1 = K_HASH; end
      "?": begin o.multi = 1'b0; o.k1 = K_QUEST; end
      ";": begin o.multi = 1'b0; o.k1 = K_SEMI; end
      "~": begin o.multi = 1'b0; o.k1 = K_TILDE; end
      "<": begin o.k1 = K_LT; o.c2 = "="; o.k2 = K_LE; end
      ">": begin o.k1 = K_GT; o.c2 = "="; o.k2 = K_GE; end
      "/": begin o.k1 = K_SLASH; o.c2 = "="; o.k2 = K_SLASH_AS; end
      "!": begin o.k1 = K_BANG; o.c2 = "="; o.k2 = K_NE; end
      ":": begin o.k1 = K_COLON; o.c2 = ":"; o.k2 = K_DCOLON; o.c3 = "="; o.k3 = K_COLON_AS; end
      "=": begin o.k1 = K_ASSIGN; o.c2 = "="; o.k2 = K_EQ; end
      "^": begin o.k1 = K_XOR; o.c2 = "="; o.k2 = K_XOR_AS; end
      "*": begin o.k1 = K_STAR; o.c2 = "="; o.k2 = K_STAR_AS; end
      "%": begin o.k1 = K_MOD; o.c2 = "="; o.k2 = K_MOD_AS; end
      "+": begin o.k1 = K_PLUS; o.c2 = "="; o.k2 = K_PLUS_AS; o.c3 = "+"; o.k3 = K_INC; end
      "-": begin o.k1 = K_MINUS; o.c2 = "="; o.k2 = K_MINUS_AS; o.c3 = "-"; o.k3 = K_DEC; end
      "&": begin o.k1 = K_AND; o.c2 = "="; o.k2 = K_AND_AS; o.c3 = "&"; o.k3 = K_LAND; end
      "|": begin o.k1 = K_OR; o.c2 = "="; o.k2 = K_OR_AS; o.c3 = "|"; o.k3 = K_LOR; end
      default: o.hit = 1'b0;
    endcase
    return o;
  endfunction

endpackage

// File: rtl/cst_step.sv
// cst_step: one pass of the scanner state machine over the current byte
// depends on cst_pkg; instantiated three times in a chain by c_style_token_scanner
module cst_step #(
  parameter int OFFSET_BITS      = cst_pkg::OFFSET_BITS_DEF,
  parameter int MAX_COMMENT_NEST = cst_pkg::MAX_NEST_DEF,
  localparam int DW = $clog2(MAX_COMMENT_NEST + 1)
) (
  input  logic [cst_pkg::OPT_W-1:0]  opts,
  input  logic [7:0]                 b,
  input  logic [OFFSET_BITS-1:0]     cur,
  input  cst_pkg::scan_st_t          st_in,
  input  logic [OFFSET_BITS-1:0]     ts_in,
  input  logic [DW-1:0]              dep_in,
  output cst_pkg::scan_st_t          st_out,
  output logic [OFFSET_BITS-1:0]     ts_out,
  output logic [DW-1:0]              dep_out,
  output logic                       take,
  output logic                       ended,
  output logic                       e_valid,
  output logic [cst_pkg::KIND_W-1:0] e_kind,
  output logic [OFFSET_BITS-1:0]     e_start,
  output logic [OFFSET_BITS-1:0]     e_end,
  output logic [cst_pkg::VAL_W-1:0]  e_value,
  output logic [cst_pkg::ERR_W-1:0]  e_err
);

  always_comb begin
    cst_pkg::scan_st_t st;
    cst_pkg::op_info_t oi;
    logic [OFFSET_BITS-1:0] ts;
    logic [DW-1:0] dep;
    logic [4:0] hv, base_eff;
    logic [3:0] d;
    logic d_ok, isd, ise, ovf, do_fin, fin_take;
    logic [cst_pkg::KIND_W-1:0] fin_kind;
    logic [67:0] prod;
    logic [cst_pkg::VAL_W-1:0] add_acc;
    logic [cst_pkg::ERR_W-1:0] add_err;
    logic [8:0] esc;

    st = st_in;
    ts = ts_in;
    dep = dep_in;
    take = 1'b0;
    ended = 1'b0;
    e_valid = 1'b0;
    e_kind = cst_pkg::K_EOF;
    e_start = cur;
    e_end = cur;
    e_value = '0;
    e_err = cst_pkg::E_NONE;
    do_fin = 1'b0;
    fin_take = 1'b0;
    fin_kind = cst_pkg::K_EOF;

    hv  = cst_pkg::hexval(b);
    isd = cst_pkg::is_dig(b);
    ise = (b == "e") || (b == "E");
    esc = cst_pkg::escape_of(b);
    oi  = cst_pkg::op_info(st_in.acc[7:0]);

    // digit accumulate: overflow when acc*base+d does not fit 64 bits
    base_eff = (st_in.base == 5'd0) ? cst_pkg::BASE_10 : st_in.base;
    d_ok = hv < base_eff;
    d = d_ok ? hv[3:0] : 4'd0;
    prod = {4'd0, st_in.acc} * 68'(base_eff) + 68'(d);
    ovf = |prod[67:64];
    add_acc = ovf ? '0 : prod[63:0];
    if (st_in.err != cst_pkg::E_NONE) add_err = st_in.err;
    else if (!d_ok) add_err = cst_pkg::E_RANGE;
    else if (ovf) add_err = cst_pkg::E_OVF;
    else add_err = cst_pkg::E_NONE;

    case (st_in.mode)
      cst_pkg::M_NAME: begin
        if (cst_pkg::is_alpha(b) || isd || b == "_") take = 1'b1;
        else begin do_fin = 1'b1; fin_kind = cst_pkg::K_NAME; end
      end
      cst_pkg::M_ZERO: begin
        if (b == "x" || b == "X") begin
          st.base = cst_pkg::BASE_16; st.mode = cst_pkg::M_INT; take = 1'b1;
        end else if (b == "b" || b == "B") begin
          st.base = cst_pkg::BASE_2; st.mode = cst_pkg::M_INT; take = 1'b1;
        end else if (isd) begin
          st.base = cst_pkg::BASE_8; st.mode = cst_pkg::M_NUM;
        end else if (b == ".") begin
          st.mode = cst_pkg::M_FRAC; take = 1'b1;
        end else if (ise) begin
          st.mode = cst_pkg::M_EXP; take = 1'b1;
        end else if (hv < 5'd16) begin
          st.mode = cst_pkg::M_INT;
        end else begin
          do_fin = 1'b1; fin_kind = cst_pkg::K_INT;
        end
      end
      cst_pkg::M_NUM, cst_pkg::M_NUM_OVF: begin
        if (isd) begin
          if (st_in.mode == cst_pkg::M_NUM) begin
            st.acc = add_acc;
            st.err = add_err;
            if (ovf) st.mode = cst_pkg::M_NUM_OVF;
          end
          take = 1'b1;
        end else if (b == ".") begin
          st.err = cst_pkg::E_NONE; st.mode = cst_pkg::M_FRAC; take = 1'b1;
        end else if (ise) begin
          st.err = cst_pkg::E_NONE; st.mode = cst_pkg::M_EXP; take = 1'b1;
        end else if (st_in.mode == cst_pkg::M_NUM && hv < 5'd16) begin
          st.mode = cst_pkg::M_INT;
        end else begin
          do_fin = 1'b1; fin_kind = cst_pkg::K_INT;
        end
      end
      cst_pkg::M_INT: begin
        if (hv >= 5'd16) begin
          do_fin = 1'b1; fin_kind = cst_pkg::K_INT;
        end else begin
          st.acc = add_acc;
          st.err = add_err;
          if (!ovf) take = 1'b1;
          else if (isd) begin st.mode = cst_pkg::M_INT_SKIP; take = 1'b1; end
          else begin do_fin = 1'b1; fin_kind = cst_pkg::K_INT; end
        end
      end
      cst_pkg::M_INT_SKIP: begin
        if (isd) take = 1'b1;
        else begin do_fin = 1'b1; fin_kind = cst_pkg::K_INT; end
      end
      cst_pkg::M_FRAC: begin
        if (isd) take = 1'b1;
        else if (ise) begin st.mode = cst_pkg::M_EXP; take = 1'b1; end
        else begin do_fin = 1'b1; fin_kind = cst_pkg::K_FLOAT; end
      end
      cst_pkg::M_EXP: begin
        if (b == "+" || b == "-") begin st.mode = cst_pkg::M_EXP_SIGN; take = 1'b1; end
        else if (isd) begin st.mode = cst_pkg::M_EXP_DIG; take = 1'b1; end
        else begin
          if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_EXP;
          do_fin = 1'b1; fin_kind = cst_pkg::K_FLOAT;
        end
      end
      cst_pkg::M_EXP_SIGN: begin
        if (isd) begin st.mode = cst_pkg::M_EXP_DIG; take = 1'b1; end
        else begin
          if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_EXP;
          do_fin = 1'b1; fin_kind = cst_pkg::K_FLOAT;
        end
      end
      cst_pkg::M_EXP_DIG: begin
        if (isd) take = 1'b1;
        else begin do_fin = 1'b1; fin_kind = cst_pkg::K_FLOAT; end
      end
      cst_pkg::M_DOT: begin
        if (st_in.dots >= 2'd2) begin
          if (b == ".") begin
            st.dots = 2'd0; do_fin = 1'b1; fin_kind = cst_pkg::K_ELLIPSIS; fin_take = 1'b1;
          end else begin
            // two dots then something else: first dot leaves, second is retried
            e_valid = 1'b1; e_kind = cst_pkg::K_DOT;
            e_start = ts_in; e_end = ts_in + 1'b1;
            ts = ts_in + 1'b1;
            st.dots = 2'd1;
          end
        end else if (isd) begin
          st.dots = 2'd0; st.mode = cst_pkg::M_FRAC; take = 1'b1;
        end else if (b == ".") begin
          st.dots = 2'd2; take = 1'b1;
        end else begin
          e_valid = 1'b1; e_kind = cst_pkg::K_DOT;
          e_start = ts_in; e_end = ts_in + 1'b1;
          st.dots = 2'd0; st.mode = cst_pkg::M_IDLE;
        end
      end
      cst_pkg::M_OP1: begin
        take = 1'b1;
        if (b == oi.c2) begin
          e_valid = 1'b1; e_kind = oi.k2; e_start = ts_in; e_end = cur + 1'b1;
          st.mode = cst_pkg::M_IDLE;
        end else if (oi.c3 != 8'h00 && b == oi.c3) begin
          e_valid = 1'b1; e_kind = oi.k3; e_start = ts_in; e_end = cur + 1'b1;
          st.mode = cst_pkg::M_IDLE;
        end else if ((st_in.acc[7:0] == "<" || st_in.acc[7:0] == ">") &&
                     b == st_in.acc[7:0]) begin
          st.mode = cst_pkg::M_OP2;
        end else if (st_in.acc[7:0] == "<" && b == "!" && opts[cst_pkg::OPT_XML]) begin
          st.mode = cst_pkg::M_XML;
        end else if (st_in.acc[7:0] == "/" && b == "/" && opts[cst_pkg::OPT_LINE]) begin
          st.mode = cst_pkg::M_LINE;
        end else if (st_in.acc[7:0] == "/" && b == "*" && opts[cst_pkg::OPT_BLOCK]) begin
          dep = DW'(1); st.mode = cst_pkg::M_BLK;
        end else begin
          take = 1'b0;
          st.acc = '0; do_fin = 1'b1; fin_kind = oi.k1;
        end
      end
      cst_pkg::M_OP2: begin
        st.acc = '0;
        do_fin = 1'b1;
        if (b == "=") begin
          fin_take = 1'b1;
          fin_kind = (st_in.acc[7:0] == "<") ? cst_pkg::K_LSHIFT_AS : cst_pkg::K_RSHIFT_AS;
        end else begin
          fin_kind = (st_in.acc[7:0] == "<") ? cst_pkg::K_LSHIFT : cst_pkg::K_RSHIFT;
        end
      end
      cst_pkg::M_CHAR_OPEN: begin
        if (b == 8'h00) begin
          if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_CHAR_OPEN;
          do_fin = 1'b1; fin_kind = cst_pkg::K_INT;
        end else if (b == "'") begin
          if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_CHAR_EMPTY;
          st.mode = cst_pkg::M_CHAR_CLOSE; take = 1'b1;
        end else if (b == 8'h0a) begin
          if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_CHAR_NL;
          do_fin = 1'b1; fin_kind = cst_pkg::K_INT;
        end else if (b == "\\") begin
          st.mode = cst_pkg::M_CHAR_ESC; take = 1'b1;
        end else begin
          st.acc = 64'(b); st.mode = cst_pkg::M_CHAR_CLOSE; take = 1'b1;
        end
      end
      cst_pkg::M_CHAR_ESC: begin
        if (b == 8'h00) begin
          if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_CHAR_OPEN;
          do_fin = 1'b1; fin_kind = cst_pkg::K_INT;
        end else begin
          if (esc[8]) begin
            if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_CHAR_ESC;
            st.acc = '0;
          end else st.acc = 64'(esc[7:0]);
          st.mode = cst_pkg::M_CHAR_CLOSE; take = 1'b1;
        end
      end
      cst_pkg::M_CHAR_CLOSE: begin
        do_fin = 1'b1; fin_kind = cst_pkg::K_INT;
        if (b == "'") fin_take = 1'b1;
        else if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_CHAR_OPEN;
      end
      cst_pkg::M_STR: begin
        if (b == "\"") begin
          do_fin = 1'b1; fin_kind = cst_pkg::K_STR; fin_take = 1'b1;
        end else if (b == 8'h00) begin
          if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_STR_OPEN;
          do_fin = 1'b1; fin_kind = cst_pkg::K_STR;
        end else begin
          take = 1'b1;
          if (b == 8'h0a && opts[cst_pkg::OPT_STR_NONL]) begin
            if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_STR_BAD;
          end else if (b == "\\" && opts[cst_pkg::OPT_STR_ESC]) st.mode = cst_pkg::M_STR_ESC;
        end
      end
      cst_pkg::M_STR_ESC: begin
        if (b == 8'h00) begin
          if (st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_STR_OPEN;
          do_fin = 1'b1; fin_kind = cst_pkg::K_STR;
        end else begin
          if (esc[8] && st.err == cst_pkg::E_NONE) st.err = cst_pkg::E_STR_BAD;
          st.mode = cst_pkg::M_STR; take = 1'b1;
        end
      end
      cst_pkg::M_LINE: begin
        if (b == 8'h0a || b == 8'h00) st.mode = cst_pkg::M_IDLE;
        else take = 1'b1;
      end
      cst_pkg::M_XML: begin
        if (b == 8'h00) st.mode = cst_pkg::M_IDLE;
        else begin
          take = 1'b1;
          if (b == ">") st.mode = cst_pkg::M_IDLE;
        end
      end
      cst_pkg::M_BLK, cst_pkg::M_BLK_SLASH, cst_pkg::M_BLK_STAR: begin
        if (b == 8'h00) begin
          dep = '0; st.mode = cst_pkg::M_IDLE;
        end else begin
          take = 1'b1;
          if (st_in.mode == cst_pkg::M_BLK_SLASH && b == "*") begin
            // nesting saturates
            if (dep_in < DW'(MAX_COMMENT_NEST)) dep = dep_in + 1'b1;
            st.mode = cst_pkg::M_BLK;
          end else if (st_in.mode == cst_pkg::M_BLK_STAR && b == "/") begin
            if (dep_in != '0) dep = dep_in - 1'b1;
            st.mode = (dep == '0) ? cst_pkg::M_IDLE : cst_pkg::M_BLK;
          end else if (b == "/") st.mode = cst_pkg::M_BLK_SLASH;
          else if (b == "*") st.mode = cst_pkg::M_BLK_STAR;
          else st.mode = cst_pkg::M_BLK;
        end
      end
      default: begin
        // between tokens: start a new one at this byte
        ts = cur;
        st.err = cst_pkg::E_NONE;
        st.acc = '0;
        st.base = cst_pkg::BASE_10;
        st.dots = 2'd0;
        st.mode = cst_pkg::M_IDLE;
        take = 1'b1;
        oi = cst_pkg::op_info(b);
        if (b == 8'h00) begin
          e_valid = 1'b1; e_kind = cst_pkg::K_EOF; ended = 1'b1;
        end else if (b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0b || b == 8'h0c) begin
          e_valid = 1'b0;
        end else if (b == 8'h0a) begin
          e_valid = !opts[cst_pkg::OPT_NO_NL]; e_kind = cst_pkg::K_NL; e_end = cur + 1'b1;
        end else if (b == "'") st.mode = cst_pkg::M_CHAR_OPEN;
        else if (b == "\"") st.mode = cst_pkg::M_STR;
        else if (b == ".") begin
          st.mode = cst_pkg::M_DOT; st.dots = 2'd1;
        end else if (b == "0") st.mode = cst_pkg::M_ZERO;
        else if (isd) begin
          st.acc = 64'(hv); st.mode = cst_pkg::M_NUM;
        end else if (cst_pkg::is_alpha(b) || b == "_") st.mode = cst_pkg::M_NAME;
        else if (oi.hit) begin
          if (!oi.multi) begin
            e_valid = 1'b1; e_kind = oi.k1; e_end = cur + 1'b1;
          end else begin
            st.acc = 64'(b); st.mode = cst_pkg::M_OP1;
          end
        end else begin
          e_valid = 1'b1; e_kind = cst_pkg::K_INVALID; e_end = cur + 1'b1;
          e_err = cst_pkg::E_BAD_BYTE;
        end
      end
    endcase

    if (do_fin) begin
      e_valid = 1'b1;
      e_kind  = fin_kind;
      e_start = ts_in;
      e_end   = fin_take ? cur + 1'b1 : cur;
      e_value = (fin_kind == cst_pkg::K_INT) ? st.acc : '0;
      e_err   = st.err;
      st.mode = cst_pkg::M_IDLE;
      take    = fin_take;
    end

    st_out  = st;
    ts_out  = ts;
    dep_out = dep;
  end

endmodule

// File: rtl/c_style_token_scanner.sv
// c_style_token_scanner: byte-stream lexer for c-style text, top level
// depends on cst_pkg and cst_step
//
// One text byte is taken per request; byte 0 ends the text, emits the end token and restarts
// offsets at 0. The scanner state feeds a chain of three step units that settle the byte
// combinationally, and the tokens it completes (zero to three) land in a result register that
// drains one token per cycle while token_ready is high. While token_ready is high, a byte
// that completes at most one token lets ordinary text run at one byte per clock; a byte that
// completes more tokens holds the input until its earlier tokens have left. text_ready is high
// when the result register is empty or its last token leaves in the same cycle.
module c_style_token_scanner #(
  parameter int OFFSET_BITS      = cst_pkg::OFFSET_BITS_DEF,
  parameter int MAX_COMMENT_NEST = cst_pkg::MAX_NEST_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [cst_pkg::OPT_W-1:0]  cfg_write_data,
  input  logic                       text_valid,
  output logic                       text_ready,
  input  logic [7:0]                 text_byte,
  output logic                       token_valid,
  input  logic                       token_ready,
  output logic [cst_pkg::KIND_W-1:0] token_class,
  output logic [cst_pkg::POS_W-1:0]  start_offset,
  output logic [cst_pkg::POS_W-1:0]  end_offset,
  output logic [cst_pkg::VAL_W-1:0]  integer_value,
  output logic [cst_pkg::ERR_W-1:0]  error_code,
  output logic                       last_of_run
);

  localparam int DW = $clog2(MAX_COMMENT_NEST + 1);
  localparam int NS = 3;

  logic [cst_pkg::OPT_W-1:0] syntax_options;
  cst_pkg::scan_st_t         st;
  logic [OFFSET_BITS-1:0]    pos, tstart;
  logic [DW-1:0]             depth;

  cst_pkg::scan_st_t       s_st [NS+1];
  logic [OFFSET_BITS-1:0]  s_ts [NS+1];
  logic [DW-1:0]           s_dep [NS+1];
  logic [NS-1:0]           s_take, s_ended, s_ev;
  logic [cst_pkg::KIND_W-1:0] s_kind [NS];
  logic [OFFSET_BITS-1:0]  s_start [NS], s_end [NS];
  logic [cst_pkg::VAL_W-1:0] s_val [NS];
  logic [cst_pkg::ERR_W-1:0] s_err [NS];

  assign s_st[0]  = st;
  assign s_ts[0]  = tstart;
  assign s_dep[0] = depth;

  for (genvar i = 0; i < NS; i++) begin : g_step
    cst_step #(
      .OFFSET_BITS      (OFFSET_BITS),
      .MAX_COMMENT_NEST (MAX_COMMENT_NEST)
    ) u_step (
      .opts    (syntax_options),
      .b       (text_byte),
      .cur     (pos),
      .st_in   (s_st[i]),
      .ts_in   (s_ts[i]),
      .dep_in  (s_dep[i]),
      .st_out  (s_st[i+1]),
      .ts_out  (s_ts[i+1]),
      .dep_out (s_dep[i+1]),
      .take    (s_take[i]),
      .ended   (s_ended[i]),
      .e_valid (s_ev[i]),
      .e_kind  (s_kind[i]),
      .e_start (s_start[i]),
      .e_end   (s_end[i]),
      .e_value (s_val[i]),
      .e_err   (s_err[i])
    );
  end

  // a later step only counts when no earlier one took the byte
  logic [NS-1:0] act, v;
  assign act = {~(s_take[0] | s_take[1]), ~s_take[0], 1'b1};
  assign v   = act & s_ev;

  cst_pkg::scan_st_t      st_next;
  logic [OFFSET_BITS-1:0] ts_next;
  logic [DW-1:0]          dep_next;
  logic                   text_end;

  always_comb begin
    if (s_take[0]) begin
      st_next = s_st[1]; ts_next = s_ts[1]; dep_next = s_dep[1];
    end else if (s_take[1]) begin
      st_next = s_st[2]; ts_next = s_ts[2]; dep_next = s_dep[2];
    end else begin
      st_next = s_st[3]; ts_next = s_ts[3]; dep_next = s_dep[3];
    end
    text_end = |(act & s_ended);
    if (text_end) begin
      st_next.mode = cst_pkg::M_IDLE;
      st_next.dots = 2'd0;
      dep_next = '0;
    end
  end

  // result register, three token slots
  logic [cst_pkg::KIND_W-1:0] r_kind [NS];
  logic [OFFSET_BITS-1:0]     r_start [NS], r_end [NS];
  logic [cst_pkg::VAL_W-1:0]  r_val [NS];
  logic [cst_pkg::ERR_W-1:0]  r_err [NS];
  logic [1:0]                 cnt, idx, cnt_next;
  logic [1:0]                 sel0, sel1;

  assign cnt_next = 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
  assign sel0 = v[0] ? 2'd0 : (v[1] ? 2'd1 : 2'd2);
  assign sel1 = (v[0] && v[1]) ? 2'd1 : 2'd2;

  assign token_valid = idx < cnt;
  assign text_ready  = (idx >= cnt) || ((idx + 2'd1 == cnt) && token_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      syntax_options <= '0;
      st.mode <= cst_pkg::M_IDLE;
      st.acc  <= '0;
      st.base <= cst_pkg::BASE_10;
      st.dots <= 2'd0;
      st.err  <= cst_pkg::E_NONE;
      pos     <= '0;
      tstart  <= '0;
      depth   <= '0;
      cnt     <= 2'd0;
      idx     <= 2'd0;
    end else begin
      if (cfg_write_en) syntax_options <= cfg_write_data;
      if (text_valid && text_ready) begin
        st     <= st_next;
        tstart <= ts_next;
        depth  <= dep_next;
        pos    <= text_end ? '0 : pos + 1'b1;
        cnt    <= cnt_next;
        idx    <= 2'd0;
      end else if (token_valid && token_ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      r_kind[0] <= s_kind[sel0]; r_start[0] <= s_start[sel0]; r_end[0] <= s_end[sel0];
      r_val[0]  <= s_val[sel0];  r_err[0]   <= s_err[sel0];
      r_kind[1] <= s_kind[sel1]; r_start[1] <= s_start[sel1]; r_end[1] <= s_end[sel1];
      r_val[1]  <= s_val[sel1];  r_err[1]   <= s_err[sel1];
      r_kind[2] <= s_kind[2];    r_start[2] <= s_start[2];    r_end[2] <= s_end[2];
      r_val[2]  <= s_val[2];     r_err[2]   <= s_err[2];
    end
  end

  assign token_class   = r_kind[idx];
  assign start_offset  = cst_pkg::POS_W'(r_start[idx]);
  assign end_offset    = cst_pkg::POS_W'(r_end[idx]);
  assign integer_value = r_val[idx];
  assign error_code    = r_err[idx];
  assign last_of_run   = (idx + 2'd1 == cnt);

endmodule

// File: rtl/cst_checker.sv
// cst_checker: port-level checks of the c-style token scanner
// depends on cst_pkg; bound to c_style_token_scanner below
module cst_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       token_valid,
  input logic                       token_ready,
  input logic [cst_pkg::KIND_W-1:0] token_class,
  input logic [cst_pkg::POS_W-1:0]  start_offset,
  input logic [cst_pkg::POS_W-1:0]  end_offset,
  input logic [cst_pkg::VAL_W-1:0]  integer_value,
  input logic [cst_pkg::ERR_W-1:0]  error_code,
  input logic                       last_of_run
);

  // a stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token_class) &&
    $stable(start_offset) && $stable(integer_value))
    else $error("stalled token changed");

  // end token closes its byte's run and is empty
  a_eof: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_class == cst_pkg::K_EOF |->
    last_of_run && start_offset == end_offset && error_code == cst_pkg::E_NONE)
    else $error("bad end token");

  // only integer and char literals carry a value
  a_value: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_class != cst_pkg::K_INT |-> integer_value == '0)
    else $error("value on non-integer token");

  // invalid byte token always reports the bad byte error
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_class == cst_pkg::K_INVALID |-> error_code == cst_pkg::E_BAD_BYTE)
    else $error("invalid token without error");

endmodule

bind c_style_token_scanner cst_checker u_cst_checker (
  .clk           (clk),
  .rst           (rst),
  .token_valid   (token_valid),
  .token_ready   (token_ready),
  .token_class   (token_class),
  .start_offset  (start_offset),
  .end_offset    (end_offset),
  .integer_value (integer_value),
  .error_code    (error_code),
  .last_of_run   (last_of_run)
);

// File: bench/token_checker.sv
`timescale 1ns / 1ps
// token_checker: watches the text and token channels of the c-style token scanner,
// predicts each token from the accepted bytes and compares; depends on cst_pkg
module token_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [cst_pkg::OPT_W-1:0]  cfg_write_data,
  input  logic                       text_valid,
  input  logic                       text_ready,
  input  logic [7:0]                 text_byte,
  input  logic                       token_valid,
  input  logic                       token_ready,
  input  logic [cst_pkg::KIND_W-1:0] token_class,
  input  logic [cst_pkg::POS_W-1:0]  start_offset,
  input  logic [cst_pkg::POS_W-1:0]  end_offset,
  input  logic [cst_pkg::VAL_W-1:0]  integer_value,
  input  logic [cst_pkg::ERR_W-1:0]  error_code,
  input  logic                       last_of_run,
  output int                         errors,
  output int                         outstanding,
  output int                         tokens_seen
);

  typedef struct packed {
    logic [cst_pkg::KIND_W-1:0] kind;
    logic [cst_pkg::POS_W-1:0]  s;
    logic [cst_pkg::POS_W-1:0]  e;
    logic [cst_pkg::VAL_W-1:0]  v;
    logic [cst_pkg::ERR_W-1:0]  err;
    logic                       last;
  } token_t;

  localparam int OPS = 25;
  localparam logic [7:0] OP_CH [OPS] = '{"(", ")", "{", "}", "[", "]", ",", "@", "#", "?",
    ";", "~", "<", ">", "/", "!", ":", "=", "^", "*", "%", "+", "-", "&", "|"};
  localparam logic [cst_pkg::KIND_W-1:0] OP_K1 [OPS] = '{
    cst_pkg::K_LPAREN, cst_pkg::K_RPAREN, cst_pkg::K_LBRACE, cst_pkg::K_RBRACE,
    cst_pkg::K_LBRACK, cst_pkg::K_RBRACK, cst_pkg::K_COMMA, cst_pkg::K_AT,
    cst_pkg::K_HASH, cst_pkg::K_QUEST, cst_pkg::K_SEMI, cst_pkg::K_TILDE,
    cst_pkg::K_LT, cst_pkg::K_GT, cst_pkg::K_SLASH, cst_pkg::K_BANG, cst_pkg::K_COLON,
    cst_pkg::K_ASSIGN, cst_pkg::K_XOR, cst_pkg::K_STAR, cst_pkg::K_MOD, cst_pkg::K_PLUS,
    cst_pkg::K_MINUS, cst_pkg::K_AND, cst_pkg::K_OR};
  localparam logic [7:0] OP_C2 [OPS] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    "=", "=", "=", "=", ":", "=", "=", "=", "=", "=", "=", "=", "="};
  localparam logic [cst_pkg::KIND_W-1:0] OP_K2 [OPS] = '{
    cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF,
    cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF,
    cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_LE, cst_pkg::K_GE, cst_pkg::K_SLASH_AS,
    cst_pkg::K_NE, cst_pkg::K_DCOLON, cst_pkg::K_EQ, cst_pkg::K_XOR_AS,
    cst_pkg::K_STAR_AS, cst_pkg::K_MOD_AS, cst_pkg::K_PLUS_AS, cst_pkg::K_MINUS_AS,
    cst_pkg::K_AND_AS, cst_pkg::K_OR_AS};
  localparam logic [7:0] OP_C3 [OPS] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, "=", 0, 0, 0, 0, "+", "-", "&", "|"};
  localparam logic [cst_pkg::KIND_W-1:0] OP_K3 [OPS] = '{
    cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF,
    cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF,
    cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF,
    cst_pkg::K_EOF, cst_pkg::K_COLON_AS, cst_pkg::K_EOF, cst_pkg::K_EOF, cst_pkg::K_EOF,
    cst_pkg::K_EOF, cst_pkg::K_INC, cst_pkg::K_DEC, cst_pkg::K_LAND, cst_pkg::K_LOR};

  logic [cst_pkg::OPT_W-1:0] opts;
  cst_pkg::mode_t            md;
  logic [cst_pkg::POS_W-1:0] pos, tstart, cur;
  logic [cst_pkg::VAL_W-1:0] acc;
  int unsigned               base, depth, dots;
  logic [cst_pkg::ERR_W-1:0] perr;
  bit                        ended;
  token_t                    step_toks[$];
  token_t                    expected_tokens[$];

  function automatic bit dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit exp_mark(logic [7:0] b);
    return b == "e" || b == "E";
  endfunction

  function automatic int unsigned hex_digit(logic [7:0] b);
    if (dig(b)) return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return 16;
  endfunction

  function automatic int unsigned esc_code(logic [7:0] b);
    case (b)
      "n": return 10;
      "r": return 13;
      "t": return 9;
      "v": return 11;
      "b": return 8;
      "a": return 7;
      "f": return 12;
      "0": return 0;
      "\\": return 92;
      "'": return 39;
      "\"": return 34;
      "?": return 63;
      default: return 256;
    endcase
  endfunction

  function automatic void flag(logic [cst_pkg::ERR_W-1:0] e);
    if (perr == cst_pkg::E_NONE) perr = e;
  endfunction

  function automatic void put(logic [cst_pkg::KIND_W-1:0] k, logic [cst_pkg::POS_W-1:0] s,
                              logic [cst_pkg::POS_W-1:0] e, logic [cst_pkg::VAL_W-1:0] v,
                              logic [cst_pkg::ERR_W-1:0] err);
    token_t t;
    t = '{kind: k, s: s, e: e, v: v, err: err, last: 1'b0};
    if (step_toks.size() < 3) step_toks.push_back(t);
  endfunction

  function automatic bit close_tok(logic [cst_pkg::KIND_W-1:0] k, bit take);
    put(k, tstart, take ? cur + 1 : cur, k == cst_pkg::K_INT ? acc : '0, perr);
    md = cst_pkg::M_IDLE;
    return take;
  endfunction

  // true on overflow, value then cleared
  function automatic bit add_digit(int unsigned d);
    logic [cst_pkg::VAL_W-1:0] bb, dd;
    bb = base ? cst_pkg::VAL_W'(base) : 64'd10;
    dd = cst_pkg::VAL_W'(d);
    if (dd >= bb) begin
      flag(cst_pkg::E_RANGE);
      dd = '0;
    end
    if (acc > ({cst_pkg::VAL_W{1'b1}} - dd) / bb) begin
      flag(cst_pkg::E_OVF);
      acc = '0;
      return 1;
    end
    acc = acc * bb + dd;
    return 0;
  endfunction

  function automatic bit start_token(logic [7:0] b);
    tstart = cur;
    perr = cst_pkg::E_NONE;
    acc = '0;
    base = 10;
    dots = 0;
    if (b == 0) begin
      put(cst_pkg::K_EOF, cur, cur, '0, cst_pkg::E_NONE);
      ended = 1;
      return 1;
    end
    if (b == " " || b == 8'd9 || b == 8'd13 || b == 8'd11 || b == 8'd12) return 1;
    if (b == 8'd10) begin
      if (!opts[cst_pkg::OPT_NO_NL]) put(cst_pkg::K_NL, cur, cur + 1, '0, cst_pkg::E_NONE);
      return 1;
    end
    if (b == "'") begin md = cst_pkg::M_CHAR_OPEN; return 1; end
    if (b == "\"") begin md = cst_pkg::M_STR; return 1; end
    if (b == ".") begin md = cst_pkg::M_DOT; dots = 1; return 1; end
    if (b == "0") begin md = cst_pkg::M_ZERO; return 1; end
    if (dig(b)) begin acc = cst_pkg::VAL_W'(b - 8'h30); md = cst_pkg::M_NUM; return 1; end
    if (letter(b) || b == "_") begin md = cst_pkg::M_NAME; return 1; end
    for (int i = 0; i < OPS; i++) begin
      if (OP_CH[i] == b) begin
        if (OP_C2[i] == 0) put(OP_K1[i], cur, cur + 1, '0, cst_pkg::E_NONE);
        else begin
          acc = cst_pkg::VAL_W'(i);
          md = cst_pkg::M_OP1;
        end
        return 1;
      end
    end
    put(cst_pkg::K_INVALID, cur, cur + 1, '0, cst_pkg::E_BAD_BYTE);
    return 1;
  endfunction

  // one pass over the byte; false means the byte is looked at again
  function automatic bit scan_byte(logic [7:0] b);
    int unsigned v, idx;
    idx = acc < OPS ? int'(acc) : 0;
    case (md)
      cst_pkg::M_NAME: begin
        if (letter(b) || dig(b) || b == "_") return 1;
        return close_tok(cst_pkg::K_NAME, 0);
      end
      cst_pkg::M_ZERO: begin
        if (b == "x" || b == "X") begin base = 16; md = cst_pkg::M_INT; return 1; end
        if (b == "b" || b == "B") begin base = 2; md = cst_pkg::M_INT; return 1; end
        if (dig(b)) begin base = 8; md = cst_pkg::M_NUM; return 0; end
        if (b == ".") begin md = cst_pkg::M_FRAC; return 1; end
        if (exp_mark(b)) begin md = cst_pkg::M_EXP; return 1; end
        if (hex_digit(b) < 16) begin md = cst_pkg::M_INT; return 0; end
        return close_tok(cst_pkg::K_INT, 0);
      end
      cst_pkg::M_NUM, cst_pkg::M_NUM_OVF: begin
        if (dig(b)) begin
          if (md == cst_pkg::M_NUM && add_digit(b - "0")) md = cst_pkg::M_NUM_OVF;
          return 1;
        end
        if (b == ".") begin perr = cst_pkg::E_NONE; md = cst_pkg::M_FRAC; return 1; end
        if (exp_mark(b)) begin perr = cst_pkg::E_NONE; md = cst_pkg::M_EXP; return 1; end
        if (md == cst_pkg::M_NUM && hex_digit(b) < 16) begin
          md = cst_pkg::M_INT;
          return 0;
        end
        return close_tok(cst_pkg::K_INT, 0);
      end
      cst_pkg::M_INT: begin
        v = hex_digit(b);
        if (v >= 16) return close_tok(cst_pkg::K_INT, 0);
        if (add_digit(v)) begin
          if (dig(b)) begin md = cst_pkg::M_INT_SKIP; return 1; end
          return close_tok(cst_pkg::K_INT, 0);
        end
        return 1;
      end
      cst_pkg::M_INT_SKIP: begin
        if (dig(b)) return 1;
        return close_tok(cst_pkg::K_INT, 0);
      end
      cst_pkg::M_FRAC: begin
        if (dig(b)) return 1;
        if (exp_mark(b)) begin md = cst_pkg::M_EXP; return 1; end
        return close_tok(cst_pkg::K_FLOAT, 0);
      end
      cst_pkg::M_EXP: begin
        if (b == "+" || b == "-") begin md = cst_pkg::M_EXP_SIGN; return 1; end
        if (dig(b)) begin md = cst_pkg::M_EXP_DIG; return 1; end
        flag(cst_pkg::E_EXP);
        return close_tok(cst_pkg::K_FLOAT, 0);
      end
      cst_pkg::M_EXP_SIGN: begin
        if (dig(b)) begin md = cst_pkg::M_EXP_DIG; return 1; end
        flag(cst_pkg::E_EXP);
        return close_tok(cst_pkg::K_FLOAT, 0);
      end
      cst_pkg::M_EXP_DIG: begin
        if (dig(b)) return 1;
        return close_tok(cst_pkg::K_FLOAT, 0);
      end
      cst_pkg::M_DOT: begin
        if (dots >= 2) begin
          if (b == ".") begin dots = 0; return close_tok(cst_pkg::K_ELLIPSIS, 1); end
          // two dots then something else: first dot goes out alone
          put(cst_pkg::K_DOT, tstart, tstart + 1, '0, cst_pkg::E_NONE);
          tstart = tstart + 1;
          dots = 1;
          return 0;
        end
        if (dig(b)) begin dots = 0; md = cst_pkg::M_FRAC; return 1; end
        if (b == ".") begin dots = 2; return 1; end
        put(cst_pkg::K_DOT, tstart, tstart + 1, '0, cst_pkg::E_NONE);
        dots = 0;
        md = cst_pkg::M_IDLE;
        return 0;
      end
      cst_pkg::M_OP1: begin
        if (b == OP_C2[idx]) begin
          put(OP_K2[idx], tstart, cur + 1, '0, cst_pkg::E_NONE);
          md = cst_pkg::M_IDLE;
          return 1;
        end
        if (OP_C3[idx] != 0 && b == OP_C3[idx]) begin
          put(OP_K3[idx], tstart, cur + 1, '0, cst_pkg::E_NONE);
          md = cst_pkg::M_IDLE;
          return 1;
        end
        if ((OP_CH[idx] == "<" || OP_CH[idx] == ">") && b == OP_CH[idx]) begin
          md = cst_pkg::M_OP2;
          return 1;
        end
        if (OP_CH[idx] == "<" && b == "!" && opts[cst_pkg::OPT_XML]) begin
          md = cst_pkg::M_XML;
          return 1;
        end
        if (OP_CH[idx] == "/" && b == "/" && opts[cst_pkg::OPT_LINE]) begin
          md = cst_pkg::M_LINE;
          return 1;
        end
        if (OP_CH[idx] == "/" && b == "*" && opts[cst_pkg::OPT_BLOCK]) begin
          depth = 1;
          md = cst_pkg::M_BLK;
          return 1;
        end
        acc = '0;
        return close_tok(OP_K1[idx], 0);
      end
      cst_pkg::M_OP2: begin
        acc = '0;
        if (b == "=")
          return close_tok(OP_CH[idx] == "<" ? cst_pkg::K_LSHIFT_AS : cst_pkg::K_RSHIFT_AS, 1);
        return close_tok(OP_CH[idx] == "<" ? cst_pkg::K_LSHIFT : cst_pkg::K_RSHIFT, 0);
      end
      cst_pkg::M_CHAR_OPEN: begin
        if (b == 0) begin flag(cst_pkg::E_CHAR_OPEN); return close_tok(cst_pkg::K_INT, 0); end
        if (b == "'") begin flag(cst_pkg::E_CHAR_EMPTY); md = cst_pkg::M_CHAR_CLOSE; return 1; end
        if (b == 8'd10) begin flag(cst_pkg::E_CHAR_NL); return close_tok(cst_pkg::K_INT, 0); end
        if (b == "\\") begin md = cst_pkg::M_CHAR_ESC; return 1; end
        acc = cst_pkg::VAL_W'(b);
        md = cst_pkg::M_CHAR_CLOSE;
        return 1;
      end
      cst_pkg::M_CHAR_ESC: begin
        if (b == 0) begin flag(cst_pkg::E_CHAR_OPEN); return close_tok(cst_pkg::K_INT, 0); end
        v = esc_code(b);
        if (v > 255) begin flag(cst_pkg::E_CHAR_ESC); v = 0; end
        acc = cst_pkg::VAL_W'(v);
        md = cst_pkg::M_CHAR_CLOSE;
        return 1;
      end
      cst_pkg::M_CHAR_CLOSE: begin
        if (b == "'") return close_tok(cst_pkg::K_INT, 1);
        flag(cst_pkg::E_CHAR_OPEN);
        return close_tok(cst_pkg::K_INT, 0);
      end
      cst_pkg::M_STR: begin
        if (b == "\"") return close_tok(cst_pkg::K_STR, 1);
        if (b == 0) begin flag(cst_pkg::E_STR_OPEN); return close_tok(cst_pkg::K_STR, 0); end
        if (b == 8'd10 && opts[cst_pkg::OPT_STR_NONL]) flag(cst_pkg::E_STR_BAD);
        else if (b == "\\" && opts[cst_pkg::OPT_STR_ESC]) md = cst_pkg::M_STR_ESC;
        return 1;
      end
      cst_pkg::M_STR_ESC: begin
        if (b == 0) begin flag(cst_pkg::E_STR_OPEN); return close_tok(cst_pkg::K_STR, 0); end
        if (esc_code(b) > 255) flag(cst_pkg::E_STR_BAD);
        md = cst_pkg::M_STR;
        return 1;
      end
      cst_pkg::M_LINE: begin
        if (b == 8'd10 || b == 0) begin md = cst_pkg::M_IDLE; return 0; end
        return 1;
      end
      cst_pkg::M_XML: begin
        if (b == 0) begin md = cst_pkg::M_IDLE; return 0; end
        if (b == ">") md = cst_pkg::M_IDLE;
        return 1;
      end
      cst_pkg::M_BLK, cst_pkg::M_BLK_SLASH, cst_pkg::M_BLK_STAR: begin
        if (b == 0) begin depth = 0; md = cst_pkg::M_IDLE; return 0; end
        if (md == cst_pkg::M_BLK_SLASH && b == "*") begin
          if (depth < cst_pkg::MAX_NEST_DEF) depth++;
          md = cst_pkg::M_BLK;
          return 1;
        end
        if (md == cst_pkg::M_BLK_STAR && b == "/") begin
          if (depth > 0) depth--;
          md = depth == 0 ? cst_pkg::M_IDLE : cst_pkg::M_BLK;
          return 1;
        end
        md = b == "/" ? cst_pkg::M_BLK_SLASH :
             (b == "*" ? cst_pkg::M_BLK_STAR : cst_pkg::M_BLK);
        return 1;
      end
      default: begin
        md = cst_pkg::M_IDLE;
        return start_token(b);
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] b);
    cur = pos;
    ended = 0;
    step_toks.delete();
    for (int i = 0; i < 6; i++) begin
      if (scan_byte(b)) break;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
    if (ended) begin
      md = cst_pkg::M_IDLE;
      pos = '0;
      depth = 0;
      dots = 0;
    end else begin
      pos = cur + 1;
    end
  endfunction

  always @(posedge clk) begin
    token_t got, want;
    if (rst) begin
      opts = '0;
      md = cst_pkg::M_IDLE;
      pos = '0;
      tstart = '0;
      acc = '0;
      base = 10;
      depth = 0;
      dots = 0;
      perr = cst_pkg::E_NONE;
      errors = 0;
      tokens_seen = 0;
      expected_tokens.delete();
    end else begin
      if (token_valid && token_ready) begin
        got = '{kind: token_class, s: start_offset, e: end_offset, v: integer_value,
                err: error_code, last: last_of_run};
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("%0t: token with nothing expected: kind %0d start %0d end %0d",
                   $time, got.kind, got.s, got.e);
        end else begin
          want = expected_tokens.pop_front();
          if (got != want) begin
            errors++;
            $display("%0t: expected kind %0d start %0d end %0d val %0h err %0d last %0b",
                     $time, want.kind, want.s, want.e, want.v, want.err, want.last);
            $display("%0t:   actual kind %0d start %0d end %0d val %0h err %0d last %0b",
                     $time, got.kind, got.s, got.e, got.v, got.err, got.last);
          end
        end
      end
      if (text_valid && text_ready) predict_tokens(text_byte);
      if (cfg_write_en) opts = cfg_write_data;
    end
    outstanding = expected_tokens.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: drives text bytes and option writes into the c-style token scanner
// depends on cst_pkg, the scanner rtl and token_checker
module testbench;

  localparam int WATCHDOG = 5000;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write_en;
  logic [cst_pkg::OPT_W-1:0]  cfg_write_data;
  logic                       text_valid;
  logic                       text_ready;
  logic [7:0]                 text_byte;
  logic                       token_valid;
  logic                       token_ready;
  logic [cst_pkg::KIND_W-1:0] token_class;
  logic [cst_pkg::POS_W-1:0]  start_offset;
  logic [cst_pkg::POS_W-1:0]  end_offset;
  logic [cst_pkg::VAL_W-1:0]  integer_value;
  logic [cst_pkg::ERR_W-1:0]  error_code;
  logic                       last_of_run;
  int                         errors, outstanding, tokens_seen;
  int                         bytes_sent, idle_cycles;
  bit                         calm;
  logic [7:0]                 frag[$];

  c_style_token_scanner dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .text_valid(text_valid), .text_ready(text_ready), .text_byte(text_byte),
    .token_valid(token_valid), .token_ready(token_ready),
    .token_class(token_class), .start_offset(start_offset), .end_offset(end_offset),
    .integer_value(integer_value), .error_code(error_code), .last_of_run(last_of_run)
  );

  token_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .text_valid(text_valid), .text_ready(text_ready), .text_byte(text_byte),
    .token_valid(token_valid), .token_ready(token_ready),
    .token_class(token_class), .start_offset(start_offset), .end_offset(end_offset),
    .integer_value(integer_value), .error_code(error_code), .last_of_run(last_of_run),
    .errors(errors), .outstanding(outstanding), .tokens_seen(tokens_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int stall;
    token_ready = 1'b0;
    stall = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall > 0) begin
        token_ready = 1'b0;
        stall--;
      end else begin
        token_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && text_ready) || (token_valid && token_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no request moved for %0d cycles", $time, WATCHDOG);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      text_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_valid = 1'b1;
    text_byte = b;
    do @(posedge clk); while (!text_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frag();
    foreach (frag[i]) send_byte(frag[i]);
    frag.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // drains the scanner, then writes the options register
  task automatic write_options(logic [cst_pkg::OPT_W-1:0] v);
    text_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_write_data = v;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // one well-formed or deliberately broken lexeme with random content
  task automatic make_lexeme();
    string digs, hexs, ops[$];
    int n;
    logic [7:0] ws [6];
    digs = "0123456789";
    hexs = "0123456789abcdefABCDEF";
    ws = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    ops = '{"<<=", ">>=", "<<", ">>", "<=", ">=", "::", ":=", "++", "--", "&&", "||",
            "+=", "-=", "&=", "|=", "^=", "*=", "%=", "/=", "!=", "==", "(", ")", "{",
            "}", "[", "]", ",", "@", "#", "?", ";", "~", "!", ":", "=", "^", "*", "%",
            "+", "-", "&", "|", "<", ">", "/"};
    case ($urandom_range(0, 13))
      0: begin
        frag.push_back(pick_char("abzAZ_q"));
        repeat ($urandom_range(0, 5)) frag.push_back(pick_char("az09_QX"));
      end
      1: begin
        frag.push_back(pick_char("123456789"));
        n = $urandom_range(0, 3) == 0 ? $urandom_range(18, 24) : $urandom_range(0, 4);
        repeat (n) frag.push_back(pick_char(digs));
      end
      2: begin
        add_str($urandom_range(0, 1) ? "0x" : "0X");
        n = $urandom_range(0, 3) == 0 ? $urandom_range(15, 18) : $urandom_range(0, 4);
        repeat (n) frag.push_back(pick_char(hexs));
      end
      3: begin
        add_str("0b");
        repeat ($urandom_range(1, 8)) frag.push_back(pick_char("01012"));
      end
      4: begin
        add_str("0");
        repeat ($urandom_range(1, 4)) frag.push_back(pick_char("01234567789ab"));
      end
      5: begin
        repeat ($urandom_range(0, 3)) frag.push_back(pick_char(digs));
        if ($urandom_range(0, 2) != 0) add_str(".");
        repeat ($urandom_range(0, 3)) frag.push_back(pick_char(digs));
        if ($urandom_range(0, 1)) begin
          frag.push_back(pick_char("eE"));
          if ($urandom_range(0, 1)) frag.push_back(pick_char("+-"));
          repeat ($urandom_range(0, 2)) frag.push_back(pick_char(digs));
        end
      end
      6: begin
        add_str("'");
        case ($urandom_range(0, 5))
          0: frag.push_back(8'd10);
          1: ;
          2: begin
            add_str("\\");
            frag.push_back(pick_char("nrtvbaf0\\'\"?qx"));
          end
          default: frag.push_back(8'($urandom_range(32, 255)));
        endcase
        if ($urandom_range(0, 5) != 0) add_str("'");
      end
      7: begin
        add_str("\"");
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: begin
              add_str("\\");
              frag.push_back(pick_char("nt0\\\"zq"));
            end
            1: frag.push_back(8'd10);
            default: frag.push_back(pick_char("ab xy'/*"));
          endcase
        end
        if ($urandom_range(0, 6) != 0) add_str("\"");
      end
      8, 9: add_str(ops[$urandom_range(0, ops.size() - 1)]);
      10: begin
        case ($urandom_range(0, 2))
          0: begin
            add_str("/*");
            repeat ($urandom_range(0, 6))
              add_str($urandom_range(0, 2) == 0 ? "/*" : ($urandom_range(0, 1) ? "*/" : "a"));
            add_str("*/");
          end
          1: begin
            add_str("//");
            repeat ($urandom_range(0, 4)) frag.push_back(pick_char("a */"));
            frag.push_back(8'd10);
          end
          default: begin
            add_str("<!");
            repeat ($urandom_range(0, 4)) frag.push_back(pick_char("-a <"));
            add_str(">");
          end
        endcase
      end
      11: repeat ($urandom_range(1, 4)) add_str(".");
      12: frag.push_back(ws[$urandom_range(0, 5)]);
      default: frag.push_back(8'($urandom_range(1, 255)));
    endcase
    if ($urandom_range(0, 2) == 0) add_str(" ");
  endtask

  initial begin
    logic [cst_pkg::OPT_W-1:0] settings[$];
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    text_valid = 1'b0;
    text_byte = '0;
    bytes_sent = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: name, hex, octal, binary, bad exponent, dots, shift-assign, char, open string of high bytes, end
    add_str("a_1 0x1F 09 0b2 1e ... <<= 'a' \"s");
    frag.push_back(8'h80);
    frag.push_back(8'hFF);
    frag.push_back(8'h00);
    send_frag();

    settings = '{6'd63, 6'd0, 6'd1, 6'd62};
    repeat (4) settings.push_back(6'($urandom_range(0, 63)));
    foreach (settings[p]) begin
      write_options(settings[p]);
      while (bytes_sent < 25 + (p + 1) * 54) begin
        if ($urandom_range(0, 19) == 0) calm = ~calm;
        make_lexeme();
        if ($urandom_range(0, 15) == 0) frag.push_back(8'h00);
        send_frag();
      end
      send_byte(8'h00);
    end
    text_valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("sent %0d text bytes over %0d option settings, %0d tokens compared",
             bytes_sent, settings.size() + 1, tokens_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
